// File: sv/cascaded_biquad_lowpass_core_defines.svh
// Assertion macros used by the biquad cascade controller.
`ifndef CASCADED_BIQUAD_LOWPASS_CORE_DEFINES_SVH
`define CASCADED_BIQUAD_LOWPASS_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CBQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cbq: same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CBQ_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cbq: next-cycle check failed");

`endif

// File: sv/cbq_pkg.sv
// Shared types, constants and section coefficient table for the biquad cascade.
package cbq_pkg;

   localparam int DATA_W           = 32;
   localparam int SAMPLE_W         = 24;
   localparam int FF_W             = 24;
   localparam int COEF_W           = 9;
   localparam int FF_REGS          = 5;
   localparam int SECT_IDX_W       = 3;
   localparam int CSR_INDEX_W      = 3;
   localparam int DEFAULT_SECTIONS = 5;
   localparam int DEFAULT_CHANNELS = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_STEREO_MODE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECTION0_FF = 3'd1;

   localparam logic [FF_W-1:0] FF_RESET [FF_REGS] = '{
      24'd978702, 24'd1305107, 24'd1502742, 24'd1244946, 24'd791052
   };

   typedef struct packed {
      logic signed [COEF_W-1:0] a0;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
      logic                     in_shift_two;
      logic                     add_input;
      logic                     out_shift_six;
   } sect_const_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL_IN,
      OP_MUL_A2,
      OP_MUL_A1,
      OP_FEEDBACK,
      OP_MUL_B0,
      OP_MUL_B1,
      OP_MUL_B2,
      OP_SECT_END,
      OP_DELIVER
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_IN,
      ST_MUL_A2,
      ST_MUL_A1,
      ST_FEEDBACK,
      ST_MUL_B0,
      ST_MUL_B1,
      ST_MUL_B2,
      ST_SECT_END,
      ST_DELIVER
   } ctrl_state_type;

   typedef struct packed {
      op_type                  op;
      logic [SECT_IDX_W-1:0]   sect;
   } cmd_type;

   typedef struct packed {
      logic out_full;
   } status_type;

   // Fixed feedback coefficients and shifts of each section. The sixth
   // section has no feedback at all.
   function automatic sect_const_type sect_const(input logic [SECT_IDX_W-1:0] s);
      sect_const_type c;
      case (s)
         3'd0: c = '{a0: -9'sd82,  a1: 9'sd185, a2: -9'sd68,
                     in_shift_two: 1'b1, add_input: 1'b1, out_shift_six: 1'b0};
         3'd1: c = '{a0: -9'sd150, a1: 9'sd187, a2: -9'sd76,
                     in_shift_two: 1'b1, add_input: 1'b0, out_shift_six: 1'b0};
         3'd2: c = '{a0: -9'sd150, a1: 9'sd191, a2: -9'sd90,
                     in_shift_two: 1'b1, add_input: 1'b0, out_shift_six: 1'b0};
         3'd3: c = '{a0: -9'sd150, a1: 9'sd197, a2: -9'sd106,
                     in_shift_two: 1'b0, add_input: 1'b0, out_shift_six: 1'b1};
         3'd4: c = '{a0: -9'sd150, a1: 9'sd206, a2: -9'sd121,
                     in_shift_two: 1'b0, add_input: 1'b0, out_shift_six: 1'b0};
         default: c = '{a0: 9'sd0, a1: 9'sd0, a2: 9'sd0,
                        in_shift_two: 1'b1, add_input: 1'b0, out_shift_six: 1'b1};
      endcase
      return c;
   endfunction

endpackage

// File: sv/cascaded_biquad_lowpass_core.sv
// Top level of the five-section fixed-point biquad low-pass cascade.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_stall  req_sample_in[23:0] signed, req_channel
//   rsp_      out        rsp_valid / rsp_stall  rsp_sample_out[31:0] signed
//   csr_      in         csr_write_en           csr_index[2:0], csr_write_data[23:0]
//
// Each request runs from acceptance to the next acceptance as a load step, eight steps per
// section on the shared 32x9 multiplier and accumulator, and a final step that moves the
// result into the output register. Reset is synchronous and active high; it restores the
// register defaults and marks every history row empty, so all history reads as zero. A
// stalled result waits in the output register while the next request is processed; only
// the final hand-over waits for that register to free up.
module cascaded_biquad_lowpass_core #(
   parameter int SECTIONS = cbq_pkg::DEFAULT_SECTIONS,
   parameter int CHANNELS = cbq_pkg::DEFAULT_CHANNELS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cbq_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                                   req_channel,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cbq_pkg::DATA_W-1:0]      rsp_sample_out,
   input  logic                                   csr_write_en,
   input  logic [cbq_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [cbq_pkg::FF_W-1:0]               csr_write_data
);
   import cbq_pkg::*;

   // Commands flow from the sequencer to the datapath; the datapath reports back
   // whether its output register still holds an undelivered result.
   cmd_type    cmd;
   status_type status;

   cbq_ctrl #(
      .SECTIONS (SECTIONS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the configuration registers, the history memory with its
   // per-row valid bits, the multiply-accumulate unit and the output register.
   cbq_datapath #(
      .SECTIONS (SECTIONS),
      .CHANNELS (CHANNELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample_in  (req_sample_in),
      .req_channel    (req_channel),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_sample_out (rsp_sample_out),
      .rsp_stall      (rsp_stall)
   );

endmodule

// File: sv/cbq_datapath.sv
// Datapath of the biquad cascade: shared multiplier, accumulator, history memory, registers.
module cbq_datapath #(
   parameter int SECTIONS = cbq_pkg::DEFAULT_SECTIONS,
   parameter int CHANNELS = cbq_pkg::DEFAULT_CHANNELS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cbq_pkg::cmd_type                       cmd,
   output cbq_pkg::status_type                    status,
   input  logic signed [cbq_pkg::SAMPLE_W-1:0]    req_sample_in,
   input  logic                                   req_channel,
   input  logic                                   csr_write_en,
   input  logic [cbq_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [cbq_pkg::FF_W-1:0]               csr_write_data,
   output logic                                   rsp_valid,
   output logic signed [cbq_pkg::DATA_W-1:0]      rsp_sample_out,
   input  logic                                   rsp_stall
);
   import cbq_pkg::*;

   localparam int Rows = SECTIONS * CHANNELS;
   localparam int RowW = (Rows > 1) ? $clog2(Rows) : 1;

   logic                  stereo_ff;
   logic [FF_W-1:0]       ff_ff [FF_REGS];

   logic [DATA_W-1:0]     x_ff, p_ff, acc_ff, w0_ff;
   logic [DATA_W-1:0]     x_in, p_in, acc_in, w0_in;
   logic                  ch_ff;
   logic                  ch_eff;

   logic [2*DATA_W-1:0]   hist_mem [Rows];
   logic [Rows-1:0]       row_valid_ff;
   logic [2*DATA_W-1:0]   rd_q_ff;
   logic                  rd_valid_ff;
   logic [RowW-1:0]       row_idx;
   int                    row_int;

   logic                  rsp_valid_ff;
   logic [DATA_W-1:0]     rsp_data_ff;

   sect_const_type        sc;
   logic [FF_W-1:0]       ff_sel;
   logic [DATA_W-1:0]     w1, w2;
   logic [DATA_W-1:0]     mul_a;
   logic signed [COEF_W-1:0] mul_c;
   logic signed [DATA_W+COEF_W-1:0] prod_full;
   logic [DATA_W-1:0]     term, sum;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stereo_ff <= 1'b0;
         for (int k = 0; k < FF_REGS; k++) begin
            ff_ff[k] <= FF_RESET[k];
         end
      end else if (csr_write_en) begin
         if (csr_index == CSR_STEREO_MODE) begin
            stereo_ff <= csr_write_data[0];
         end
         for (int k = 0; k < FF_REGS; k++) begin
            if (csr_index == CSR_INDEX_W'(int'(CSR_SECTION0_FF) + k)) begin
               ff_ff[k] <= csr_write_data;
            end
         end
      end
   end

   assign sc     = sect_const(cmd.sect);
   assign ff_sel = (int'(cmd.sect) < FF_REGS) ? ff_ff[cmd.sect] : '0;
   assign ch_eff = (CHANNELS > 1) ? ch_ff : 1'b0;

   assign row_int = int'(cmd.sect) * CHANNELS + int'(ch_eff);
   assign row_idx = row_int[RowW-1:0];

   // History of a row that was never written reads as zero.
   assign w1 = rd_valid_ff ? rd_q_ff[DATA_W-1:0] : '0;
   assign w2 = rd_valid_ff ? rd_q_ff[2*DATA_W-1:DATA_W] : '0;

   always_comb begin
      mul_a = x_ff;
      mul_c = '0;
      case (cmd.op)
         OP_MUL_IN: begin mul_a = x_ff;  mul_c = sc.a0; end
         OP_MUL_A2: begin mul_a = w2;    mul_c = sc.a2; end
         OP_MUL_A1: begin mul_a = w1;    mul_c = sc.a1; end
         OP_MUL_B0: begin
            mul_a = w0_ff;
            mul_c = COEF_W'($signed(ff_sel[7:0]));
         end
         OP_MUL_B1: begin
            mul_a = w1;
            mul_c = COEF_W'($signed(ff_sel[15:8]));
         end
         OP_MUL_B2: begin
            mul_a = w2;
            mul_c = COEF_W'($signed(ff_sel[23:16]));
         end
         default: begin mul_a = x_ff; mul_c = '0; end
      endcase
   end

   // Only the low word of each product is kept, which gives the 32-bit wrap.
   assign prod_full = $signed(mul_a) * mul_c;
   assign p_in      = prod_full[DATA_W-1:0];

   assign term = sc.in_shift_two ? DATA_W'($signed(p_ff) >>> 2)
                                 : DATA_W'($signed(p_ff) >>> 1);
   assign sum  = acc_ff + p_ff;

   always_comb begin
      x_in   = x_ff;
      acc_in = acc_ff;
      w0_in  = w0_ff;
      case (cmd.op)
         OP_LOAD:     x_in   = DATA_W'($signed(req_sample_in));
         OP_MUL_A2:   acc_in = sc.add_input ? term : (DATA_W'(0) - term);
         OP_MUL_A1:   acc_in = sum;
         OP_FEEDBACK: w0_in  = DATA_W'($signed(sum) >>> 7);
         OP_MUL_B1:   acc_in = p_ff;
         OP_MUL_B2:   acc_in = sum;
         OP_SECT_END: x_in   = sc.out_shift_six ? DATA_W'($signed(sum) >>> 6)
                                                : DATA_W'($signed(sum) >>> 7);
         default:     x_in   = x_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      p_ff   <= p_in;
      acc_ff <= acc_in;
      w0_ff  <= w0_in;
      if (cmd.op == OP_LOAD) begin
         ch_ff <= stereo_ff & req_channel;
      end
   end

   // History memory: one row of (w2, w1) per section and channel.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_MUL_IN) begin
         rd_q_ff     <= hist_mem[row_idx];
         rd_valid_ff <= row_valid_ff[row_idx];
      end
      if (cmd.op == OP_SECT_END) begin
         hist_mem[row_idx] <= {w1, w0_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.op == OP_SECT_END) begin
         row_valid_ff[row_idx] <= 1'b1;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_DELIVER) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_DELIVER) begin
         rsp_data_ff <= x_ff;
      end
   end

   assign status.out_full = rsp_valid_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = $signed(rsp_data_ff);

endmodule

// File: sv/cbq_ctrl.sv
// Controller of the biquad cascade: sequences the load, eight steps per section and the delivery.
`include "cascaded_biquad_lowpass_core_defines.svh"

module cbq_ctrl #(
   parameter int SECTIONS = cbq_pkg::DEFAULT_SECTIONS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 rsp_stall,
   input  cbq_pkg::status_type  status,
   output cbq_pkg::cmd_type     cmd
);
   import cbq_pkg::*;

   localparam logic [SECT_IDX_W-1:0] LastSect = SECT_IDX_W'(SECTIONS - 1);

   ctrl_state_type          state_ff, state_in;
   logic [SECT_IDX_W-1:0]   sect_ff, sect_in;
   logic                    accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sect_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sect_ff  <= sect_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sect_in  = sect_ff;
      cmd.op   = OP_IDLE;
      cmd.sect = sect_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_MUL_IN;
               sect_in  = '0;
            end
         end
         ST_MUL_IN: begin
            cmd.op   = OP_MUL_IN;
            state_in = ST_MUL_A2;
         end
         ST_MUL_A2: begin
            cmd.op   = OP_MUL_A2;
            state_in = ST_MUL_A1;
         end
         ST_MUL_A1: begin
            cmd.op   = OP_MUL_A1;
            state_in = ST_FEEDBACK;
         end
         ST_FEEDBACK: begin
            cmd.op   = OP_FEEDBACK;
            state_in = ST_MUL_B0;
         end
         ST_MUL_B0: begin
            cmd.op   = OP_MUL_B0;
            state_in = ST_MUL_B1;
         end
         ST_MUL_B1: begin
            cmd.op   = OP_MUL_B1;
            state_in = ST_MUL_B2;
         end
         ST_MUL_B2: begin
            cmd.op   = OP_MUL_B2;
            state_in = ST_SECT_END;
         end
         ST_SECT_END: begin
            cmd.op = OP_SECT_END;
            if (sect_ff == LastSect) begin
               state_in = ST_DELIVER;
            end else begin
               sect_in  = sect_ff + 1'b1;
               state_in = ST_MUL_IN;
            end
         end
         ST_DELIVER: begin
            if (!status.out_full || !rsp_stall) begin
               cmd.op   = OP_DELIVER;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `CBQ_ASSERT_NXT(a_accept_starts_first_section, clock, reset, accept, (state_ff == ST_MUL_IN) && (sect_ff == '0))
   `CBQ_ASSERT_NXT(a_section_advances, clock, reset, (state_ff == ST_SECT_END) && (sect_ff != LastSect), (state_ff == ST_MUL_IN) && (sect_ff == $past(sect_ff) + 1'b1))
   `CBQ_ASSERT_IMP(a_section_in_range, clock, reset, state_ff != ST_IDLE, sect_ff <= LastSect)
   `CBQ_ASSERT_NXT(a_deliver_fills_output, clock, reset, cmd.op == OP_DELIVER, status.out_full)
   `CBQ_ASSERT_NXT(a_blocked_deliver_waits, clock, reset, (state_ff == ST_DELIVER) && status.out_full && rsp_stall, state_ff == ST_DELIVER)

endmodule
